// ----- sv/crc32bs_pkg.sv -----
// ----------------------------------------------------------------------------
// crc32bs_pkg
// Shared types, constants and CRC helper functions for the byte-swapped
// streaming CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32bs_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] CrcAllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       last;
    logic       no_byte;
  } item_t;

  // Fold one byte into the remainder, least significant bit first.
  function automatic logic [31:0] fold_byte(logic [31:0] rem, logic [7:0] data);
    logic [31:0] r;
    logic        fb;
    r = rem;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ data[k];
      r  = {1'b0, r[31:1]};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] swap_bytes(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ----- sv/crc32_byte_swapped_stream.sv -----
// ----------------------------------------------------------------------------
// crc32_byte_swapped_stream
// Streaming reflected CRC-32 (poly 0xEDB88320) with a byte-swapped result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per message
//   byte: data_byte_i, start_req_i reloads the remainder to all ones first,
//   no_byte_i marks a request without a byte (zero-length message), and
//   last_i asks for the checksum once the byte is folded in.
//   Output channel (out_valid_o / out_ready_i) returns checksum_o, the
//   remainder with its bytes reversed and then inverted, once per last.
//   Throughput: one request per cycle, unless a last request waits for the
//   occupied result register; the byte fold feeding the remainder register
//   is combinational. A last request is captured in the input register,
//   then folded into the result register, where its checksum shows.
//   Reset loads the remainder with all ones and empties both registers.
//   While the receiver stalls, the result register holds; requests keep
//   flowing until one would need the occupied result register, and then
//   in_ready_o drops until it is taken.
// ----------------------------------------------------------------------------
module crc32_byte_swapped_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  input  logic        last_i,
  input  logic        no_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] checksum_o
);

  crc32bs_pkg::item_t in_item;
  crc32bs_pkg::item_t s1_item;
  logic               s1_valid;
  logic               out_free;
  logic               advance;
  logic               fire;
  logic [31:0]        checksum_next;

  assign in_item.data_byte = data_byte_i;
  assign in_item.start_req = start_req_i;
  assign in_item.last      = last_i;
  assign in_item.no_byte   = no_byte_i;

  // Advance when the result register can take a checksum, or none is due.
  assign advance = out_free || !s1_item.last;
  assign fire    = s1_valid && advance;

  crc32bs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  crc32bs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (s1_item),
    .checksum_o (checksum_next)
  );

  crc32bs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && s1_item.last),
    .checksum_i  (checksum_next),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .checksum_o  (checksum_o)
  );

endmodule

// ----- sv/crc32bs_in_stage.sv -----
// ----------------------------------------------------------------------------
// crc32bs_in_stage
// Input register: captures one request per cycle and holds it until the
// fold stage takes it.
// ----------------------------------------------------------------------------
module crc32bs_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crc32bs_pkg::item_t  item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output crc32bs_pkg::item_t  item_o
);

  logic               valid_q, valid_d;
  crc32bs_pkg::item_t item_q;
  logic               load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/crc32bs_core.sv -----
// ----------------------------------------------------------------------------
// crc32bs_core
// Running remainder register and the eight-step byte fold; forms the
// byte-swapped, inverted checksum for the last request of a message.
// ----------------------------------------------------------------------------
module crc32bs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  crc32bs_pkg::item_t  item_i,
  output logic [31:0]         checksum_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] rem_base;

  always_comb begin
    rem_base = item_i.start_req ? crc32bs_pkg::CrcAllOnes : rem_q;
    rem_d    = item_i.no_byte ? rem_base
                              : crc32bs_pkg::fold_byte(rem_base, item_i.data_byte);
  end

  // Remainder is kept after the last byte; only a start request or reset reloads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= crc32bs_pkg::CrcAllOnes;
    end else if (fire_i) begin
      rem_q <= rem_d;
    end
  end

  assign checksum_o = ~crc32bs_pkg::swap_bytes(rem_d);

endmodule

// ----- sv/crc32bs_out_stage.sv -----
// ----------------------------------------------------------------------------
// crc32bs_out_stage
// Result register: holds a finished checksum until the receiver takes it.
// ----------------------------------------------------------------------------
module crc32bs_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] checksum_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] checksum_o
);

  logic        valid_q, valid_d;
  logic [31:0] checksum_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      checksum_q <= checksum_i;
    end
  end

  assign out_valid_o = valid_q;
  assign checksum_o  = checksum_q;

endmodule
